// ===== hdl/gss_pkg.sv =====
package gss_pkg;

   typedef enum logic [1:0] {
      CMD_LOAD_CELL = 2'd0,
      CMD_LOAD_FACE = 2'd1,
      CMD_LOAD_ROW  = 2'd2,
      CMD_RUN       = 2'd3
   } command_type;

   localparam logic CSR_CELL_COUNT  = 1'b0;
   localparam logic CSR_SWEEP_COUNT = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [1:0]         command;
      logic [7:0]         index;
      logic signed [31:0] diag_coeff;
      logic signed [31:0] rhs_value;
      logic signed [31:0] initial_x;
      logic signed [31:0] upper_coeff;
      logic signed [31:0] lower_coeff;
      logic [5:0]         neighbour_cell;
      logic [8:0]         row_face_start;
   } req_type;

   typedef struct packed {
      logic [5:0]         cell_index;
      logic signed [31:0] solution;
      logic               last;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] quotient;
      logic               sat;
      logic               zero;
   } div_result_type;

   typedef struct packed {
      logic               sat;
      logic signed [31:0] value;
   } clip_type;

   function automatic clip_type clip32(input logic signed [47:0] v);
      clip_type r;
      r.sat = 1'b0;
      r.value = v[31:0];
      if (v > 48'sh0000_7fff_ffff) begin
         r.sat = 1'b1;
         r.value = Q_MAX;
      end else if (v < -48'sh0000_8000_0000) begin
         r.sat = 1'b1;
         r.value = Q_MIN;
      end
      return r;
   endfunction

   // round to nearest, ties up, then drop 16 fraction bits
   function automatic logic signed [47:0] round_q(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p + 64'sd32768;
      return s[63:16];
   endfunction

endpackage

// ===== hdl/gss_div.sv =====
module gss_div
   import gss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  num,
   input  logic signed [31:0]  den,
   output div_result_type      result
);

   logic        run_ff, run_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] dvd_ff, dvd_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   div_result_type res_ff, res_in;

   logic [32:0] trial;
   logic [32:0] diff;
   logic [31:0] num_mag, den_mag;
   logic [47:0] q_done;

   assign num_mag = num[31] ? 32'(-num) : 32'(num);
   assign den_mag = den[31] ? 32'(-den) : 32'(den);
   assign trial   = {rem_ff, dvd_ff[47]};
   assign diff    = trial - {1'b0, dvs_ff};
   assign q_done  = {dvd_ff[46:0], ~diff[32]};

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      res_in = res_ff;
      res_in.done = 1'b0;
      if (start) begin
         if (den == 32'sd0) begin
            res_in.done = 1'b1;
            res_in.zero = 1'b1;
            res_in.sat = 1'b0;
            res_in.quotient = num[31] ? Q_MIN : Q_MAX;
         end else begin
            run_in = 1'b1;
            cnt_in = '0;
            dvd_in = {num_mag, 16'b0};
            rem_in = '0;
            dvs_in = den_mag;
            neg_in = num[31] ^ den[31];
         end
      end else if (run_ff) begin
         // one quotient bit per cycle
         rem_in = diff[32] ? trial[31:0] : diff[31:0];
         dvd_in = q_done;
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            run_in = 1'b0;
            res_in.done = 1'b1;
            res_in.zero = 1'b0;
            res_in.sat = 1'b0;
            if (neg_ff) begin
               if (q_done > 48'h0000_8000_0000) begin
                  res_in.sat = 1'b1;
                  res_in.quotient = Q_MIN;
               end else begin
                  res_in.quotient = 32'(-q_done);
               end
            end else begin
               if (q_done > 48'h0000_7fff_ffff) begin
                  res_in.sat = 1'b1;
                  res_in.quotient = Q_MAX;
               end else begin
                  res_in.quotient = q_done[31:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         res_ff.done <= 1'b0;
      end else begin
         run_ff <= run_in;
         res_ff.done <= res_in.done;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      res_ff.quotient <= res_in.quotient;
      res_ff.sat <= res_in.sat;
      res_ff.zero <= res_in.zero;
   end

   assign result = res_ff;

   a_no_start_while_running: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> !start) else $error("divider restarted while busy");
   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      (run_ff && cnt_ff == 6'd47) |=> (res_ff.done && !run_ff))
      else $error("divider did not finish after 48 steps");
   a_zero_immediate: assert property (@(posedge clock) disable iff (reset)
      (start && den == 32'sd0) |=> (res_ff.done && res_ff.zero))
      else $error("zero divisor not flagged");

endmodule

// ===== hdl/ldu_gauss_seidel_smoother.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | req_payload (req_type)
// rsp     | out       | rsp_valid, rsp_stall | rsp_payload (rsp_type)
// csr     | in        | csr_write_en         | csr_index, csr_wdata
// a load item is taken only while idle; a run makes sweeps passes over the cells, each one copying
//   rhs into work and, per cell, reading the row, the upper faces, the divide and the lower faces,
//   then reports every cell; the 48-step divider (which flags a zero diagonal without iterating)
//   and the shared multiplier set its length
// memories are single ported, one access per cycle, which serializes every face
// reset is synchronous and clears the sequencer, counters and config to 1 / 1
// req_stall is high during a run; a stalled result holds until taken
module ldu_gauss_seidel_smoother
   import gss_pkg::*;
#(
   parameter int CELLS = 64,
   parameter int FACES = 256
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_payload,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_payload,
   input  logic     csr_write_en,
   input  logic     csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int CAW = $clog2(CELLS);
   localparam int CCW = $clog2(CELLS + 1);
   localparam int RAW = $clog2(CELLS + 1);
   localparam int FAW = (FACES > 1) ? $clog2(FACES) : 1;
   localparam int FCW = ($clog2(FACES + 1) > 9) ? $clog2(FACES + 1) : 9;

   typedef enum logic [19:0] {
      ST_IDLE    = 20'h00001,
      ST_COPY_RD = 20'h00002,
      ST_COPY_WR = 20'h00004,
      ST_ROW_RD0 = 20'h00008,
      ST_ROW_RD1 = 20'h00010,
      ST_ROW_RD2 = 20'h00020,
      ST_UP_RD   = 20'h00040,
      ST_UP_NB   = 20'h00080,
      ST_UP_MUL  = 20'h00100,
      ST_UP_SUB  = 20'h00200,
      ST_DIV_GO  = 20'h00400,
      ST_DIV_WT  = 20'h00800,
      ST_LO_RD   = 20'h01000,
      ST_LO_NB   = 20'h02000,
      ST_LO_MUL  = 20'h04000,
      ST_LO_SUB  = 20'h08000,
      ST_SOL_WR  = 20'h10000,
      ST_OUT_RD  = 20'h20000,
      ST_OUT_VAL = 20'h40000
   } state_type;

   state_type state_ff, state_in;
   logic [6:0]  cell_count_ff, cell_count_in;
   logic [7:0]  sweep_count_ff, sweep_count_in;
   logic [CCW-1:0] c_ff, c_in, n_ff, n_in;
   logic [7:0]  s_ff, s_in;
   logic [FCW-1:0] f_ff, f_in, fs_ff, fs_in, fe_ff, fe_in;
   logic signed [31:0] cur_ff, cur_in, coef_ff, coef_in, acc_ff, acc_in;
   logic [5:0]  nb_ff, nb_in;
   logic signed [63:0] prod_ff, prod_in;
   logic zero_ff, zero_in, sat_ff, sat_in;

   // memories
   logic signed [31:0] diag_mem [CELLS];
   logic signed [31:0] rhs_mem  [CELLS];
   logic signed [31:0] sol_mem  [CELLS];
   logic signed [31:0] work_mem [CELLS];
   logic signed [31:0] upper_mem [FACES];
   logic signed [31:0] lower_mem [FACES];
   logic [5:0]         nb_mem   [FACES];
   logic [8:0]         rs_mem   [CELLS+1];

   logic signed [31:0] diag_rd, rhs_rd, sol_rd, work_rd, upper_rd, lower_rd;
   logic [5:0] nb_rd;
   logic [8:0] rs_rd;

   logic [CAW-1:0] cell_addr, sol_addr, work_addr;
   logic [FAW-1:0] face_addr;
   logic [RAW-1:0] rs_addr;
   logic cell_we, face_we, rs_we, sol_we, work_we;
   logic signed [31:0] sol_wd, work_wd;

   logic req_xfer, rsp_xfer, idle, nb_bad, last_cell;
   logic div_start;
   div_result_type div_res;
   clip_type prod_clip, diff_clip;
   logic signed [31:0] mul_b;
   logic [6:0] cc_eff;

   assign idle      = (state_ff == ST_IDLE);
   assign req_stall = !idle;
   assign req_xfer  = req_valid && idle;
   assign rsp_valid = (state_ff == ST_OUT_VAL);
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign nb_bad    = 32'(nb_rd) >= CELLS;
   assign last_cell = (c_ff == n_ff - CCW'(1));

   assign prod_clip = clip32(round_q(prod_ff));
   assign diff_clip = clip32(48'(acc_ff) - 48'(prod_clip.value));
   assign mul_b     = (state_ff == ST_UP_MUL) ? sol_rd : cur_ff;
   assign prod_in   = coef_ff * mul_b;

   // loads only happen while idle
   assign cell_we = req_xfer && req_payload.command == CMD_LOAD_CELL
                    && 32'(req_payload.index) < CELLS;
   assign face_we = req_xfer && req_payload.command == CMD_LOAD_FACE
                    && 32'(req_payload.index) < FACES;
   assign rs_we   = req_xfer && req_payload.command == CMD_LOAD_ROW
                    && 32'(req_payload.index) <= CELLS;

   always_comb begin
      cell_addr = idle ? CAW'(req_payload.index) : CAW'(c_ff);
      face_addr = idle ? FAW'(req_payload.index) : FAW'(f_ff);
      if (idle) begin
         rs_addr = RAW'(req_payload.index);
      end else if (state_ff == ST_ROW_RD1) begin
         rs_addr = RAW'(c_ff + CCW'(1));
      end else begin
         rs_addr = RAW'(c_ff);
      end
      if (idle) begin
         sol_addr = CAW'(req_payload.index);
      end else if (state_ff == ST_UP_NB) begin
         sol_addr = CAW'(nb_rd);
      end else begin
         sol_addr = CAW'(c_ff);
      end
      if (state_ff == ST_LO_NB) begin
         work_addr = CAW'(nb_rd);
      end else if (state_ff == ST_LO_MUL || state_ff == ST_LO_SUB) begin
         work_addr = CAW'(nb_ff);
      end else begin
         work_addr = CAW'(c_ff);
      end
      sol_we  = cell_we || (state_ff == ST_SOL_WR);
      sol_wd  = idle ? req_payload.initial_x : cur_ff;
      work_we = (state_ff == ST_COPY_WR) || (state_ff == ST_LO_SUB);
      work_wd = (state_ff == ST_COPY_WR) ? rhs_rd : diff_clip.value;
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         diag_mem[cell_addr] <= req_payload.diag_coeff;
         rhs_mem[cell_addr]  <= req_payload.rhs_value;
      end
      diag_rd <= diag_mem[cell_addr];
      rhs_rd  <= rhs_mem[cell_addr];
   end

   always_ff @(posedge clock) begin
      if (sol_we) begin
         sol_mem[sol_addr] <= sol_wd;
      end
      sol_rd <= sol_mem[sol_addr];
   end

   always_ff @(posedge clock) begin
      if (work_we) begin
         work_mem[work_addr] <= work_wd;
      end
      work_rd <= work_mem[work_addr];
   end

   always_ff @(posedge clock) begin
      if (face_we) begin
         upper_mem[face_addr] <= req_payload.upper_coeff;
         lower_mem[face_addr] <= req_payload.lower_coeff;
         nb_mem[face_addr]    <= req_payload.neighbour_cell;
      end
      upper_rd <= upper_mem[face_addr];
      lower_rd <= lower_mem[face_addr];
      nb_rd    <= nb_mem[face_addr];
   end

   always_ff @(posedge clock) begin
      if (rs_we) begin
         rs_mem[rs_addr] <= req_payload.row_face_start;
      end
      rs_rd <= rs_mem[rs_addr];
   end

   gss_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (cur_ff),
      .den    (diag_rd),
      .result (div_res)
   );

   assign div_start = (state_ff == ST_DIV_GO);

   always_comb begin
      cc_eff = cell_count_ff;
      if (cell_count_ff == 7'd0) begin
         cc_eff = 7'd1;
      end else if (32'(cell_count_ff) > CELLS) begin
         cc_eff = 7'(CELLS);
      end
   end

   always_comb begin
      state_in = state_ff;
      cell_count_in = cell_count_ff;
      sweep_count_in = sweep_count_ff;
      c_in = c_ff;
      n_in = n_ff;
      s_in = s_ff;
      f_in = f_ff;
      fs_in = fs_ff;
      fe_in = fe_ff;
      cur_in = cur_ff;
      coef_in = coef_ff;
      acc_in = acc_ff;
      nb_in = nb_ff;
      zero_in = zero_ff;
      sat_in = sat_ff;
      if (csr_write_en) begin
         if (csr_index == CSR_CELL_COUNT) begin
            cell_count_in = csr_wdata[6:0];
         end else begin
            sweep_count_in = csr_wdata;
         end
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_payload.command == CMD_RUN) begin
               n_in = CCW'(cc_eff);
               c_in = '0;
               s_in = '0;
               zero_in = 1'b0;
               sat_in = 1'b0;
               state_in = (sweep_count_ff == 8'd0) ? ST_OUT_RD : ST_COPY_RD;
            end
         end
         ST_COPY_RD: state_in = ST_COPY_WR;
         ST_COPY_WR: begin
            if (last_cell) begin
               c_in = '0;
               state_in = ST_ROW_RD0;
            end else begin
               c_in = c_ff + CCW'(1);
               state_in = ST_COPY_RD;
            end
         end
         ST_ROW_RD0: state_in = ST_ROW_RD1;
         ST_ROW_RD1: begin
            cur_in = work_rd;
            f_in = FCW'(rs_rd);
            fs_in = FCW'(rs_rd);
            state_in = ST_ROW_RD2;
         end
         ST_ROW_RD2: begin
            fe_in = (32'(rs_rd) > FACES) ? FCW'(FACES) : FCW'(rs_rd);
            state_in = ST_UP_RD;
         end
         ST_UP_RD: state_in = (f_ff < fe_ff) ? ST_UP_NB : ST_DIV_GO;
         ST_UP_NB: begin
            if (nb_bad) begin
               f_in = f_ff + FCW'(1);
               state_in = ST_UP_RD;
            end else begin
               coef_in = upper_rd;
               state_in = ST_UP_MUL;
            end
         end
         ST_UP_MUL: begin
            acc_in = cur_ff;
            state_in = ST_UP_SUB;
         end
         ST_UP_SUB: begin
            cur_in = diff_clip.value;
            sat_in = sat_ff | prod_clip.sat | diff_clip.sat;
            f_in = f_ff + FCW'(1);
            state_in = ST_UP_RD;
         end
         ST_DIV_GO: state_in = ST_DIV_WT;
         ST_DIV_WT: begin
            if (div_res.done) begin
               cur_in = div_res.quotient;
               sat_in = sat_ff | div_res.sat;
               zero_in = zero_ff | div_res.zero;
               f_in = fs_ff;
               state_in = ST_LO_RD;
            end
         end
         ST_LO_RD: state_in = (f_ff < fe_ff) ? ST_LO_NB : ST_SOL_WR;
         ST_LO_NB: begin
            if (nb_bad) begin
               f_in = f_ff + FCW'(1);
               state_in = ST_LO_RD;
            end else begin
               nb_in = nb_rd;
               coef_in = lower_rd;
               state_in = ST_LO_MUL;
            end
         end
         ST_LO_MUL: begin
            acc_in = work_rd;
            state_in = ST_LO_SUB;
         end
         ST_LO_SUB: begin
            sat_in = sat_ff | prod_clip.sat | diff_clip.sat;
            f_in = f_ff + FCW'(1);
            state_in = ST_LO_RD;
         end
         ST_SOL_WR: begin
            if (last_cell) begin
               c_in = '0;
               if (s_ff == sweep_count_ff - 8'd1) begin
                  state_in = ST_OUT_RD;
               end else begin
                  s_in = s_ff + 8'd1;
                  state_in = ST_COPY_RD;
               end
            end else begin
               c_in = c_ff + CCW'(1);
               state_in = ST_ROW_RD0;
            end
         end
         ST_OUT_RD: state_in = ST_OUT_VAL;
         ST_OUT_VAL: begin
            if (rsp_xfer) begin
               if (last_cell) begin
                  state_in = ST_IDLE;
               end else begin
                  c_in = c_ff + CCW'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cell_count_ff <= 7'd1;
         sweep_count_ff <= 8'd1;
         c_ff <= '0;
         n_ff <= CCW'(1);
         s_ff <= '0;
         zero_ff <= 1'b0;
         sat_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cell_count_ff <= cell_count_in;
         sweep_count_ff <= sweep_count_in;
         c_ff <= c_in;
         n_ff <= n_in;
         s_ff <= s_in;
         zero_ff <= zero_in;
         sat_ff <= sat_in;
      end
      f_ff <= f_in;
      fs_ff <= fs_in;
      fe_ff <= fe_in;
      cur_ff <= cur_in;
      coef_ff <= coef_in;
      acc_ff <= acc_in;
      nb_ff <= nb_in;
      prod_ff <= prod_in;
   end

   always_comb begin
      rsp_payload.cell_index = 6'(c_ff);
      rsp_payload.solution = sol_rd;
      rsp_payload.last = last_cell;
      if (zero_ff) begin
         rsp_payload.status = STATUS_ZERO;
      end else if (sat_ff) begin
         rsp_payload.status = STATUS_SAT;
      end else begin
         rsp_payload.status = STATUS_OK;
      end
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("sequencer state not one-hot");
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input open while reporting");
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == ST_DIV_WT) else $error("quotient arrived unexpectedly");
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_payload.last) |=> state_ff == ST_IDLE)
      else $error("run did not end after final cell");

endmodule
